>>> design/dual_stack_bytecode_executor_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the dual stack bytecode executor unit
// Each macro takes a label, a clock, an active-low reset, the condition(s)
// and a message.
// ----------------------------------------------------------------------------
`ifndef DUAL_STACK_BYTECODE_EXECUTOR_UNIT_ASSERT_SVH
`define DUAL_STACK_BYTECODE_EXECUTOR_UNIT_ASSERT_SVH

// same-cycle implication
`define DSBE_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define DSBE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> design/dsbe_pkg.sv
// ----------------------------------------------------------------------------
// dsbe_pkg
// Shared types and constants of the dual stack bytecode executor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dsbe_pkg;

	localparam int DATA_DEPTH   = 16;
	localparam int RETURN_DEPTH = 16;
	localparam int CELL_W       = 16;
	localparam int ADDR_W       = 12;
	localparam int COUNT_W      = 5;

	localparam int DCNT_W = $clog2(DATA_DEPTH + 1);
	localparam int RCNT_W = $clog2(RETURN_DEPTH + 1);

	typedef logic [CELL_W-1:0] cell_t;
	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [DCNT_W-1:0] dcnt_t;
	typedef logic [RCNT_W-1:0] rcnt_t;

	typedef enum logic [2:0] {
		K_PUSH  = 3'd0,
		K_CALL  = 3'd1,
		K_JUMP  = 3'd2,
		K_JZ    = 3'd3,
		K_JNZ   = 3'd4,
		K_RET   = 3'd5,
		K_DO    = 3'd6,
		K_LOOP  = 3'd7
	} kind_t;

	typedef enum logic [3:0] {
		P_PRINT  = 4'd0,
		P_DUP    = 4'd1,
		P_SWAP   = 4'd2,
		P_OVER   = 4'd3,
		P_DROP   = 4'd4,
		P_ADD    = 4'd5,
		P_SUB    = 4'd6,
		P_EQ     = 4'd7,
		P_TOR    = 4'd8,
		P_FROMR  = 4'd9,
		P_RFETCH = 4'd10
	} prim_t;

	typedef enum logic [2:0] {
		ERR_NONE = 3'd0,
		ERR_DUNF = 3'd1,
		ERR_DOVF = 3'd2,
		ERR_RUNF = 3'd3,
		ERR_ROVF = 3'd4
	} err_t;

	typedef enum logic [2:0] {
		SH_NONE  = 3'd0,
		SH_PUSH1 = 3'd1,
		SH_PUSH2 = 3'd2,
		SH_POP1  = 3'd3,
		SH_POP2  = 3'd4
	} shift_t;

	// stack update request: shift first, then overwrite the two top cells
	typedef struct packed {
		shift_t shift;
		logic   wr0;
		cell_t  val0;
		logic   wr1;
		cell_t  val1;
	} stack_ctl_t;

	typedef struct packed {
		addr_t next_pc;
		logic  done;
		err_t  err;
		logic  print_valid;
		cell_t print_value;
	} exec_res_t;

endpackage

>>> design/dsbe_dstack.sv
// ----------------------------------------------------------------------------
// dsbe_dstack
// Data stack as a shift-register file: entry 0 is the top of stack.
// Also gives the top and depth as they will be after the update.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dsbe_dstack (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  dsbe_pkg::stack_ctl_t   ctl,
	output dsbe_pkg::cell_t        top,
	output dsbe_pkg::cell_t        second,
	output dsbe_pkg::dcnt_t        count,
	output dsbe_pkg::cell_t        nxt_top,
	output dsbe_pkg::dcnt_t        nxt_count
);

	localparam int DEPTH = dsbe_pkg::DATA_DEPTH;
	localparam int CW    = dsbe_pkg::DCNT_W;

	dsbe_pkg::cell_t ent_q [DEPTH];
	dsbe_pkg::cell_t nxt   [DEPTH];
	dsbe_pkg::dcnt_t count_q;

	for (genvar i = 0; i < DEPTH; i++) begin : g_ent
		localparam int UP1 = (i >= 1) ? i - 1 : i;
		localparam int UP2 = (i >= 2) ? i - 2 : i;
		localparam int DN1 = (i + 1 < DEPTH) ? i + 1 : i;
		localparam int DN2 = (i + 2 < DEPTH) ? i + 2 : i;

		always_comb begin
			nxt[i] = ent_q[i];
			case (ctl.shift)
				dsbe_pkg::SH_PUSH1: nxt[i] = ent_q[UP1];
				dsbe_pkg::SH_PUSH2: nxt[i] = ent_q[UP2];
				dsbe_pkg::SH_POP1:  nxt[i] = ent_q[DN1];
				dsbe_pkg::SH_POP2:  nxt[i] = ent_q[DN2];
				default:            nxt[i] = ent_q[i];
			endcase
			if (i == 0 && ctl.wr0) begin
				nxt[i] = ctl.val0;
			end
			if (i == 1 && ctl.wr1) begin
				nxt[i] = ctl.val1;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				ent_q[i] <= nxt[i];
			end
		end
	end

	always_comb begin
		case (ctl.shift)
			dsbe_pkg::SH_PUSH1: nxt_count = count_q + CW'(1);
			dsbe_pkg::SH_PUSH2: nxt_count = count_q + CW'(2);
			dsbe_pkg::SH_POP1:  nxt_count = count_q - CW'(1);
			dsbe_pkg::SH_POP2:  nxt_count = count_q - CW'(2);
			default:            nxt_count = count_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (en) begin
			count_q <= nxt_count;
		end
	end

	assign nxt_top = (nxt_count == '0) ? '0 : nxt[0];
	assign top     = ent_q[0];
	assign second  = ent_q[1];
	assign count   = count_q;

endmodule

>>> design/dsbe_rstack.sv
// ----------------------------------------------------------------------------
// dsbe_rstack
// Return stack as a shift-register file: entry 0 is the top of stack.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dsbe_rstack (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  dsbe_pkg::stack_ctl_t   ctl,
	output dsbe_pkg::cell_t        top,
	output dsbe_pkg::cell_t        second,
	output dsbe_pkg::rcnt_t        count
);

	localparam int DEPTH = dsbe_pkg::RETURN_DEPTH;
	localparam int CW    = dsbe_pkg::RCNT_W;

	dsbe_pkg::cell_t ent_q [DEPTH];
	dsbe_pkg::cell_t nxt   [DEPTH];
	dsbe_pkg::rcnt_t count_q;
	dsbe_pkg::rcnt_t nxt_count;

	for (genvar i = 0; i < DEPTH; i++) begin : g_ent
		localparam int UP1 = (i >= 1) ? i - 1 : i;
		localparam int UP2 = (i >= 2) ? i - 2 : i;
		localparam int DN1 = (i + 1 < DEPTH) ? i + 1 : i;
		localparam int DN2 = (i + 2 < DEPTH) ? i + 2 : i;

		always_comb begin
			nxt[i] = ent_q[i];
			case (ctl.shift)
				dsbe_pkg::SH_PUSH1: nxt[i] = ent_q[UP1];
				dsbe_pkg::SH_PUSH2: nxt[i] = ent_q[UP2];
				dsbe_pkg::SH_POP1:  nxt[i] = ent_q[DN1];
				dsbe_pkg::SH_POP2:  nxt[i] = ent_q[DN2];
				default:            nxt[i] = ent_q[i];
			endcase
			if (i == 0 && ctl.wr0) begin
				nxt[i] = ctl.val0;
			end
			if (i == 1 && ctl.wr1) begin
				nxt[i] = ctl.val1;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				ent_q[i] <= nxt[i];
			end
		end
	end

	always_comb begin
		case (ctl.shift)
			dsbe_pkg::SH_PUSH1: nxt_count = count_q + CW'(1);
			dsbe_pkg::SH_PUSH2: nxt_count = count_q + CW'(2);
			dsbe_pkg::SH_POP1:  nxt_count = count_q - CW'(1);
			dsbe_pkg::SH_POP2:  nxt_count = count_q - CW'(2);
			default:            nxt_count = count_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (en) begin
			count_q <= nxt_count;
		end
	end

	assign top    = ent_q[0];
	assign second = ent_q[1];
	assign count  = count_q;

endmodule

>>> design/dsbe_exec.sv
// ----------------------------------------------------------------------------
// dsbe_exec
// Instruction execute logic: checks operands and room, builds the update
// requests for both stacks and the result: next pc, done, error and print.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dsbe_exec (
	input  dsbe_pkg::kind_t        kind,
	input  dsbe_pkg::cell_t        literal,
	input  dsbe_pkg::addr_t        target,
	input  logic                   call_primitive,
	input  dsbe_pkg::prim_t        primitive_op,
	input  dsbe_pkg::addr_t        return_addr,
	input  dsbe_pkg::cell_t        dtop,
	input  dsbe_pkg::cell_t        dsec,
	input  dsbe_pkg::dcnt_t        dcnt,
	input  dsbe_pkg::cell_t        rtop,
	input  dsbe_pkg::cell_t        rsec,
	input  dsbe_pkg::rcnt_t        rcnt,
	output dsbe_pkg::stack_ctl_t   dctl,
	output dsbe_pkg::stack_ctl_t   rctl,
	output dsbe_pkg::exec_res_t    res
);

	logic            d_lt1;
	logic            d_lt2;
	logic            d_full;
	logic            r_lt1;
	logic            r_lt2;
	logic            r_full;
	logic            r_no2;
	dsbe_pkg::cell_t loop_idx;
	logic            loop_more;

	assign d_lt1  = (dcnt == '0);
	assign d_lt2  = (dcnt < dsbe_pkg::DCNT_W'(2));
	assign d_full = (dcnt >= dsbe_pkg::DCNT_W'(dsbe_pkg::DATA_DEPTH));
	assign r_lt1  = (rcnt == '0);
	assign r_lt2  = (rcnt < dsbe_pkg::RCNT_W'(2));
	assign r_full = (rcnt >= dsbe_pkg::RCNT_W'(dsbe_pkg::RETURN_DEPTH));
	assign r_no2  = (rcnt > dsbe_pkg::RCNT_W'(dsbe_pkg::RETURN_DEPTH - 2));

	assign loop_idx  = rtop + dtop;
	assign loop_more = ($signed(loop_idx) < $signed(rsec));

	always_comb begin
		dctl            = '0;
		dctl.shift      = dsbe_pkg::SH_NONE;
		rctl            = '0;
		rctl.shift      = dsbe_pkg::SH_NONE;
		res             = '0;
		res.next_pc     = return_addr;
		res.err         = dsbe_pkg::ERR_NONE;

		case (kind)
			dsbe_pkg::K_PUSH: begin
				if (d_full) begin
					res.err = dsbe_pkg::ERR_DOVF;
				end else begin
					dctl.shift = dsbe_pkg::SH_PUSH1;
					dctl.wr0   = 1'b1;
					dctl.val0  = literal;
				end
			end
			dsbe_pkg::K_CALL: begin
				if (call_primitive) begin
					case (primitive_op)
						dsbe_pkg::P_PRINT: begin
							if (d_lt1) begin
								res.err = dsbe_pkg::ERR_DUNF;
							end else begin
								dctl.shift      = dsbe_pkg::SH_POP1;
								res.print_valid = 1'b1;
								res.print_value = dtop;
							end
						end
						dsbe_pkg::P_DUP, dsbe_pkg::P_OVER: begin
							if (primitive_op == dsbe_pkg::P_DUP ? d_lt1 : d_lt2) begin
								res.err = dsbe_pkg::ERR_DUNF;
							end else if (d_full) begin
								res.err = dsbe_pkg::ERR_DOVF;
							end else begin
								dctl.shift = dsbe_pkg::SH_PUSH1;
								dctl.wr0   = 1'b1;
								dctl.val0  = (primitive_op == dsbe_pkg::P_DUP) ? dtop : dsec;
							end
						end
						dsbe_pkg::P_SWAP: begin
							if (d_lt2) begin
								res.err = dsbe_pkg::ERR_DUNF;
							end else begin
								dctl.wr0  = 1'b1;
								dctl.val0 = dsec;
								dctl.wr1  = 1'b1;
								dctl.val1 = dtop;
							end
						end
						dsbe_pkg::P_DROP: begin
							if (d_lt1) begin
								res.err = dsbe_pkg::ERR_DUNF;
							end else begin
								dctl.shift = dsbe_pkg::SH_POP1;
							end
						end
						dsbe_pkg::P_ADD, dsbe_pkg::P_SUB, dsbe_pkg::P_EQ: begin
							if (d_lt2) begin
								res.err = dsbe_pkg::ERR_DUNF;
							end else begin
								dctl.shift = dsbe_pkg::SH_POP1;
								dctl.wr0   = 1'b1;
								if (primitive_op == dsbe_pkg::P_ADD) begin
									dctl.val0 = dsec + dtop;
								end else if (primitive_op == dsbe_pkg::P_SUB) begin
									dctl.val0 = dsec - dtop;
								end else begin
									dctl.val0 = (dsec == dtop) ? '1 : '0;
								end
							end
						end
						dsbe_pkg::P_TOR: begin
							if (d_lt1) begin
								res.err = dsbe_pkg::ERR_DUNF;
							end else if (r_full) begin
								res.err = dsbe_pkg::ERR_ROVF;
							end else begin
								dctl.shift = dsbe_pkg::SH_POP1;
								rctl.shift = dsbe_pkg::SH_PUSH1;
								rctl.wr0   = 1'b1;
								rctl.val0  = dtop;
							end
						end
						dsbe_pkg::P_FROMR, dsbe_pkg::P_RFETCH: begin
							if (r_lt1) begin
								res.err = dsbe_pkg::ERR_RUNF;
							end else if (d_full) begin
								res.err = dsbe_pkg::ERR_DOVF;
							end else begin
								dctl.shift = dsbe_pkg::SH_PUSH1;
								dctl.wr0   = 1'b1;
								dctl.val0  = rtop;
								if (primitive_op == dsbe_pkg::P_FROMR) begin
									rctl.shift = dsbe_pkg::SH_POP1;
								end
							end
						end
						default: begin
							res.err = dsbe_pkg::ERR_NONE;
						end
					endcase
				end else begin
					res.next_pc = target;
					if (r_full) begin
						res.err = dsbe_pkg::ERR_ROVF;
					end else begin
						rctl.shift = dsbe_pkg::SH_PUSH1;
						rctl.wr0   = 1'b1;
						rctl.val0  = dsbe_pkg::CELL_W'(return_addr);
					end
				end
			end
			dsbe_pkg::K_JUMP: begin
				res.next_pc = target;
			end
			dsbe_pkg::K_JZ, dsbe_pkg::K_JNZ: begin
				if (d_lt1) begin
					res.err = dsbe_pkg::ERR_DUNF;
				end else begin
					dctl.shift = dsbe_pkg::SH_POP1;
					if ((dtop == '0) == (kind == dsbe_pkg::K_JZ)) begin
						res.next_pc = target;
					end
				end
			end
			dsbe_pkg::K_RET: begin
				if (r_lt1) begin
					res.done = 1'b1;
				end else begin
					rctl.shift  = dsbe_pkg::SH_POP1;
					res.next_pc = rtop[dsbe_pkg::ADDR_W-1:0];
				end
			end
			dsbe_pkg::K_DO: begin
				if (d_lt2) begin
					res.err = dsbe_pkg::ERR_DUNF;
				end else if (r_no2) begin
					res.err = dsbe_pkg::ERR_ROVF;
				end else begin
					// limit goes below, start ends on top
					dctl.shift = dsbe_pkg::SH_POP2;
					rctl.shift = dsbe_pkg::SH_PUSH2;
					rctl.wr0   = 1'b1;
					rctl.val0  = dsec;
					rctl.wr1   = 1'b1;
					rctl.val1  = dtop;
				end
			end
			dsbe_pkg::K_LOOP: begin
				if (d_lt1) begin
					res.err = dsbe_pkg::ERR_DUNF;
				end else if (r_lt2) begin
					res.err = dsbe_pkg::ERR_RUNF;
				end else begin
					dctl.shift = dsbe_pkg::SH_POP1;
					if (loop_more) begin
						rctl.wr0    = 1'b1;
						rctl.val0   = loop_idx;
						res.next_pc = target;
					end else begin
						rctl.shift = dsbe_pkg::SH_POP2;
					end
				end
			end
			default: begin
				res.err = dsbe_pkg::ERR_NONE;
			end
		endcase
	end

endmodule

>>> design/dual_stack_bytecode_executor_unit.sv
// Each request passes the request register, then the result register.
// Throughput: one instruction per cycle while the output is not stalled;
// both stacks update as the instruction leaves the request register.
// Reset: stack depths clear to zero; stack cell contents are undefined.
// Output stalls hold the result register; the request register takes the
// next instruction as soon as the current one moves on.
// ----------------------------------------------------------------------------
// dual_stack_bytecode_executor_unit
// Executes one decoded stack-machine instruction per request against a data
// stack and a return stack and returns next pc, status and stack view.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dual_stack_bytecode_executor_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                req_valid,
	output logic                                req_ready,
	input  logic [2:0]                          kind,
	input  logic signed [dsbe_pkg::CELL_W-1:0]  literal,
	input  logic [dsbe_pkg::ADDR_W-1:0]         target,
	input  logic                                call_primitive,
	input  logic [3:0]                          primitive_op,
	input  logic [dsbe_pkg::ADDR_W-1:0]         return_addr,
	output logic                                res_valid,
	input  logic                                res_ready,
	output logic [dsbe_pkg::ADDR_W-1:0]         next_pc,
	output logic                                done_res,
	output logic [2:0]                          error,
	output logic                                print_valid,
	output logic signed [dsbe_pkg::CELL_W-1:0]  print_value,
	output logic signed [dsbe_pkg::CELL_W-1:0]  top_value,
	output logic [dsbe_pkg::COUNT_W-1:0]        stack_count
);

	`include "dual_stack_bytecode_executor_unit_assert.svh"

	logic                 valid_s1;
	dsbe_pkg::kind_t      kind_s1;
	dsbe_pkg::cell_t      literal_s1;
	dsbe_pkg::addr_t      target_s1;
	logic                 call_primitive_s1;
	dsbe_pkg::prim_t      primitive_op_s1;
	dsbe_pkg::addr_t      return_addr_s1;

	logic                 valid_s2;
	dsbe_pkg::exec_res_t  res_s2;
	dsbe_pkg::cell_t      top_s2;
	dsbe_pkg::dcnt_t      count_s2;

	logic                 advance;
	dsbe_pkg::stack_ctl_t dctl;
	dsbe_pkg::stack_ctl_t rctl;
	dsbe_pkg::exec_res_t  res;
	dsbe_pkg::cell_t      dtop;
	dsbe_pkg::cell_t      dsec;
	dsbe_pkg::dcnt_t      dcnt;
	dsbe_pkg::cell_t      dnxt_top;
	dsbe_pkg::dcnt_t      dnxt_count;
	dsbe_pkg::cell_t      rtop;
	dsbe_pkg::cell_t      rsec;
	dsbe_pkg::rcnt_t      rcnt;

	assign advance   = valid_s1 && (!valid_s2 || res_ready);
	assign req_ready = !valid_s1 || advance;

	// request register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			kind_s1           <= dsbe_pkg::kind_t'(kind);
			literal_s1        <= literal;
			target_s1         <= target;
			call_primitive_s1 <= call_primitive;
			primitive_op_s1   <= dsbe_pkg::prim_t'(primitive_op);
			return_addr_s1    <= return_addr;
		end
	end

	dsbe_exec u_exec (
		.kind           (kind_s1),
		.literal        (literal_s1),
		.target         (target_s1),
		.call_primitive (call_primitive_s1),
		.primitive_op   (primitive_op_s1),
		.return_addr    (return_addr_s1),
		.dtop           (dtop),
		.dsec           (dsec),
		.dcnt           (dcnt),
		.rtop           (rtop),
		.rsec           (rsec),
		.rcnt           (rcnt),
		.dctl           (dctl),
		.rctl           (rctl),
		.res            (res)
	);

	dsbe_dstack u_dstack (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (advance),
		.ctl       (dctl),
		.top       (dtop),
		.second    (dsec),
		.count     (dcnt),
		.nxt_top   (dnxt_top),
		.nxt_count (dnxt_count)
	);

	dsbe_rstack u_rstack (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (advance),
		.ctl    (rctl),
		.top    (rtop),
		.second (rsec),
		.count  (rcnt)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (res_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2   <= res;
			top_s2   <= dnxt_top;
			count_s2 <= dnxt_count;
		end
	end

	assign res_valid   = valid_s2;
	assign next_pc     = res_s2.next_pc;
	assign done_res    = res_s2.done;
	assign error       = res_s2.err;
	assign print_valid = res_s2.print_valid;
	assign print_value = res_s2.print_value;
	assign top_value   = top_s2;
	assign stack_count = dsbe_pkg::COUNT_W'(count_s2);

	`DSBE_ASSERT_NEXT(a_req_lands, clk, arst_n, req_valid && req_ready, valid_s1, "accepted request not held")
	`DSBE_ASSERT_IMPL(a_done_clean, clk, arst_n, res_valid && done_res, error == dsbe_pkg::ERR_NONE, "done with error")
	`DSBE_ASSERT_IMPL(a_print_clean, clk, arst_n, res_valid && print_valid, error == dsbe_pkg::ERR_NONE, "print with error")
	`DSBE_ASSERT_IMPL(a_depth_range, clk, arst_n, 1'b1, dcnt <= dsbe_pkg::DCNT_W'(dsbe_pkg::DATA_DEPTH) && rcnt <= dsbe_pkg::RCNT_W'(dsbe_pkg::RETURN_DEPTH), "stack depth out of range")

endmodule
